### src/qse_pkg.sv
// ----------------------------------------------------------------------------
// Quoted string escape decoder package
// Shared payload types, result kind codes and queue sizing.
// ----------------------------------------------------------------------------
package qse_pkg;

   localparam int NumSlots = 5;
   localparam int CmdDepth = 4;
   localparam int CmdPtrW = $clog2(CmdDepth);
   localparam int CmdCntW = $clog2(CmdDepth + 1);
   localparam int SlotIdxW = $clog2(NumSlots);
   localparam int SlotCntW = $clog2(NumSlots + 1);

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   typedef struct packed {
      logic [7:0] ch;
      logic       first;
      logic       text_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
   } slot_type;

   typedef struct packed {
      slot_type [NumSlots-1:0] slots;
      logic [SlotCntW-1:0]     count;
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_BODY = 4'b0010,
      PH_ESC  = 4'b0100,
      PH_HEX  = 4'b1000
   } phase_type;

endpackage

### src/qse_front.sv
// ----------------------------------------------------------------------------
// Quoted string escape decoder front end
// Tracks the string phase, decodes escapes and hex code points, and builds
// one command with the ordered results of each accepted byte that has any.
// ----------------------------------------------------------------------------
module qse_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  qse_pkg::req_type  req_data,
   output logic              cmd_push,
   input  logic              cmd_full,
   output qse_pkg::cmd_type  cmd_data
);

   localparam logic [7:0] ChBackslash = 8'h5C;
   localparam logic [7:0] ChSquote = 8'h27;
   localparam logic [7:0] ChDquote = 8'h22;

   qse_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  quote_ff, quote_in;
   logic [31:0] accum_ff, accum_in;
   logic [3:0]  left_ff, left_in;

   logic        accept;
   logic        pre_err;
   logic        tail_on;
   logic [1:0]  tail_kind;
   logic [2:0]  nbytes;
   logic [3:0][7:0] bytes;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [31:0] acc_next;
   logic [3:0]  left_next;

   function automatic logic [34:0] utf8_encode(input logic [31:0] cp_raw);
      logic [20:0] cp;
      logic [34:0] r;
      if ((cp_raw >= 32'hD800 && cp_raw <= 32'hDFFF) || cp_raw > 32'h10FFFF) begin
         cp = 21'h00FFFD;
      end else begin
         cp = cp_raw[20:0];
      end
      r = '0;
      if (cp < 21'h80) begin
         r[34:32] = 3'd1;
         r[7:0] = cp[7:0];
      end else if (cp < 21'h800) begin
         r[34:32] = 3'd2;
         r[7:0] = 8'hC0 | {3'b000, cp[10:6]};
         r[15:8] = 8'h80 | {2'b00, cp[5:0]};
      end else if (cp < 21'h10000) begin
         r[34:32] = 3'd3;
         r[7:0] = 8'hE0 | {4'b0000, cp[15:12]};
         r[15:8] = 8'h80 | {2'b00, cp[11:6]};
         r[23:16] = 8'h80 | {2'b00, cp[5:0]};
      end else begin
         r[34:32] = 3'd4;
         r[7:0] = 8'hF0 | {5'b00000, cp[20:18]};
         r[15:8] = 8'h80 | {2'b00, cp[17:12]};
         r[23:16] = 8'h80 | {2'b00, cp[11:6]};
         r[31:24] = 8'h80 | {2'b00, cp[5:0]};
      end
      return r;
   endfunction

   assign req_full = cmd_full;
   assign accept = req_push && !cmd_full;

   always_comb begin
      hex_ok = 1'b1;
      hex_val = 4'd0;
      case (req_data.ch) inside
         [8'h30:8'h39]: hex_val = req_data.ch[3:0];
         [8'h41:8'h46], [8'h61:8'h66]: hex_val = req_data.ch[3:0] + 4'd9;
         default: hex_ok = 1'b0;
      endcase
   end

   assign acc_next = {accum_ff[27:0], hex_val};
   assign left_next = left_ff - 4'd1;

   always_comb begin
      logic [34:0] enc;
      phase_in = phase_ff;
      quote_in = quote_ff;
      accum_in = accum_ff;
      left_in = left_ff;
      pre_err = 1'b0;
      tail_on = 1'b0;
      tail_kind = qse_pkg::KIND_CLOSE;
      nbytes = 3'd0;
      bytes = '0;
      enc = utf8_encode(acc_next);
      if (req_data.first) begin
         pre_err = (phase_ff != qse_pkg::PH_IDLE);
         quote_in = req_data.ch;
         phase_in = qse_pkg::PH_BODY;
         accum_in = '0;
         left_in = '0;
      end else begin
         case (phase_ff)
            qse_pkg::PH_BODY: begin
               if (req_data.ch == quote_ff) begin
                  tail_on = 1'b1;
                  tail_kind = qse_pkg::KIND_CLOSE;
                  phase_in = qse_pkg::PH_IDLE;
               end else if (req_data.ch == ChBackslash) begin
                  phase_in = qse_pkg::PH_ESC;
               end else begin
                  nbytes = 3'd1;
                  bytes[0] = req_data.ch;
               end
            end
            qse_pkg::PH_ESC: begin
               phase_in = qse_pkg::PH_BODY;
               nbytes = 3'd1;
               case (req_data.ch)
                  8'h6E: bytes[0] = 8'h0A;
                  8'h72: bytes[0] = 8'h0D;
                  8'h74: bytes[0] = 8'h09;
                  8'h62: bytes[0] = 8'h08;
                  8'h66: bytes[0] = 8'h0C;
                  8'h78: begin
                     nbytes = 3'd0;
                     phase_in = qse_pkg::PH_HEX;
                     accum_in = '0;
                     left_in = 4'd2;
                  end
                  8'h75: begin
                     nbytes = 3'd0;
                     phase_in = qse_pkg::PH_HEX;
                     accum_in = '0;
                     left_in = 4'd4;
                  end
                  8'h55: begin
                     nbytes = 3'd0;
                     phase_in = qse_pkg::PH_HEX;
                     accum_in = '0;
                     left_in = 4'd8;
                  end
                  ChBackslash, ChSquote, ChDquote: bytes[0] = req_data.ch;
                  default: begin
                     nbytes = 3'd2;
                     bytes[0] = ChBackslash;
                     bytes[1] = req_data.ch;
                  end
               endcase
            end
            qse_pkg::PH_HEX: begin
               if (!hex_ok) begin
                  tail_on = 1'b1;
                  tail_kind = qse_pkg::KIND_ERROR;
                  phase_in = qse_pkg::PH_IDLE;
                  accum_in = '0;
                  left_in = '0;
               end else begin
                  accum_in = acc_next;
                  left_in = left_next;
                  if (left_next == 4'd0) begin
                     nbytes = enc[34:32];
                     bytes = enc[31:0];
                     phase_in = qse_pkg::PH_BODY;
                  end
               end
            end
            default: phase_in = qse_pkg::PH_IDLE;
         endcase
      end
      if (req_data.text_end && phase_in != qse_pkg::PH_IDLE) begin
         tail_on = 1'b1;
         tail_kind = qse_pkg::KIND_ERROR;
         phase_in = qse_pkg::PH_IDLE;
         accum_in = '0;
         left_in = '0;
      end
   end

   always_comb begin
      logic [2:0] j;
      for (int s = 0; s < qse_pkg::NumSlots; s++) begin
         cmd_data.slots[s].data = '0;
         cmd_data.slots[s].kind = qse_pkg::KIND_DATA;
         j = 3'(s) - {2'b00, pre_err};
         if (pre_err && s == 0) begin
            cmd_data.slots[s].kind = qse_pkg::KIND_ERROR;
         end else if (j < nbytes) begin
            cmd_data.slots[s].data = bytes[j[1:0]];
         end else if (j == nbytes && tail_on) begin
            cmd_data.slots[s].kind = tail_kind;
         end
      end
      cmd_data.count = {2'b00, pre_err} + nbytes + {2'b00, tail_on};
   end

   assign cmd_push = accept && (cmd_data.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= qse_pkg::PH_IDLE;
         quote_ff <= '0;
         accum_ff <= '0;
         left_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         quote_ff <= quote_in;
         accum_ff <= accum_in;
         left_ff <= left_in;
      end
   end

endmodule

### src/qse_fifo.sv
// ----------------------------------------------------------------------------
// Quoted string escape decoder command queue
// A short queue that decouples the front end from the result sequencer.
// ----------------------------------------------------------------------------
module qse_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  qse_pkg::cmd_type  push_data,
   output logic              valid,
   input  logic              pop,
   output qse_pkg::cmd_type  head_data
);

   qse_pkg::cmd_type entry_ff [qse_pkg::CmdDepth];
   logic [qse_pkg::CmdPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [qse_pkg::CmdCntW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == qse_pkg::CmdCntW'(qse_pkg::CmdDepth));
   assign valid = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop = pop && valid;
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

### src/qse_back.sv
// ----------------------------------------------------------------------------
// Quoted string escape decoder result sequencer
// Walks the results of the head command one per cycle into the output
// register, while that register is empty or being popped.
// ----------------------------------------------------------------------------
module qse_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  qse_pkg::cmd_type  cmd_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output qse_pkg::rsp_type  rsp_data
);

   logic [qse_pkg::SlotIdxW-1:0] idx_ff;
   logic out_valid_ff;
   qse_pkg::rsp_type out_ff, out_in;
   logic load;
   logic at_last;

   assign load = cmd_valid && (!out_valid_ff || rsp_pop);
   assign at_last = ({1'b0, idx_ff} == cmd_data.count - 1'b1);
   assign cmd_pop = load && at_last;

   always_comb begin
      out_in.out_byte = cmd_data.slots[idx_ff].data;
      out_in.kind = cmd_data.slots[idx_ff].kind;
      out_in.last = at_last;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            out_valid_ff <= 1'b1;
            idx_ff <= at_last ? '0 : idx_ff + 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

### src/quoted_string_escape_to_utf8_unit.sv
// ----------------------------------------------------------------------------
// Quoted string escape to UTF-8 decoder
// Decodes quoted string literals with backslash and hex escapes into UTF-8.
//
//   Channel   Ports                          Transfer when
//   input     req_push req_full req_data     req_push && !req_full
//   result    rsp_empty rsp_pop rsp_data     rsp_pop && !rsp_empty
//
// One input byte is accepted per cycle while the command queue has room.
// Each byte gives zero to five results, sent one per cycle by the sequencer
// while the output register is empty or being popped.
// Results pass through the command queue and then the output register.
// Reset is synchronous and clears the phase, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module quoted_string_escape_to_utf8_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  qse_pkg::req_type  req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output qse_pkg::rsp_type  rsp_data
);

   logic cmd_push, cmd_full, cmd_valid, cmd_pop;
   qse_pkg::cmd_type cmd_in, cmd_head;

   qse_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full),
      .cmd_data (cmd_in)
   );

   qse_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .full      (cmd_full),
      .push_data (cmd_in),
      .valid     (cmd_valid),
      .pop       (cmd_pop),
      .head_data (cmd_head)
   );

   qse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_head),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
